@@ sv/midi_note_message_parser_macros.svh @@
// Assertion macros shared by the MIDI note message parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef MIDI_NOTE_MESSAGE_PARSER_MACROS_SVH
`define MIDI_NOTE_MESSAGE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MNP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MNP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mnp_pkg.sv @@
// Shared types and constants for the MIDI note message parser.
// No dependencies; imported by every module of the block.
package mnp_pkg;

  localparam int unsigned STATUS_BIT = 7;
  localparam logic [7:0]  SYS_RESET_BYTE = 8'hFF;
  localparam logic [3:0]  CMD_SYSTEM = 4'hF;
  localparam logic [2:0]  CMD_NOTE_OFF = 3'd0;
  localparam logic [2:0]  CMD_NOTE_ON = 3'd1;

  typedef enum logic [1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_RESET    = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic        valid;
    event_kind_t kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [6:0]  velocity;
  } mnp_result_t;

endpackage

@@ sv/mnp_in_stage.sv @@
// Input register for the MIDI note message parser: holds one byte item.
// Depends on mnp_pkg.
module mnp_in_stage
  import mnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid;
  logic [7:0] byte_reg;

  assign byte_ready = !valid || advance;
  assign held_valid = valid;
  assign held_byte  = byte_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (byte_ready) begin
      valid <= byte_valid;
    end
    if (byte_valid && byte_ready) begin
      byte_reg <= data_byte;
    end
  end

endmodule

@@ sv/mnp_parser.sv @@
// Parse state machine: latches channel and key, builds the event for a byte.
// Depends on mnp_pkg.
module mnp_parser
  import mnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  cur_byte,
  output mnp_result_t result
);

  typedef enum logic [2:0] {
    ST_WAIT    = 3'd0,
    ST_OFF_KEY = 3'd1,
    ST_OFF_VEL = 3'd2,
    ST_ON_KEY  = 3'd3,
    ST_ON_VEL  = 3'd4
  } state_t;

  state_t     state, state_next;
  logic [3:0] held_channel, held_channel_next;
  logic [6:0] held_key, held_key_next;
  logic [3:0] cmd;

  assign cmd = cur_byte[7:4];

  always_comb begin
    state_next        = ST_WAIT;
    held_channel_next = held_channel;
    held_key_next     = held_key;
    result            = '0;
    result.kind       = KIND_NOTE_OFF;
    if (cur_byte[STATUS_BIT]) begin
      // a status byte always restarts parsing
      if (cmd == CMD_SYSTEM) begin
        if (cur_byte == SYS_RESET_BYTE) begin
          result.valid = 1'b1;
          result.kind  = KIND_RESET;
        end
      end else begin
        held_channel_next = cur_byte[3:0];
        if (cmd[2:0] == CMD_NOTE_OFF) begin
          state_next = ST_OFF_KEY;
        end else if (cmd[2:0] == CMD_NOTE_ON) begin
          state_next = ST_ON_KEY;
        end
      end
    end else begin
      unique case (state)
        ST_OFF_KEY: begin
          held_key_next = cur_byte[6:0];
          state_next    = ST_OFF_VEL;
        end
        ST_ON_KEY: begin
          held_key_next = cur_byte[6:0];
          state_next    = ST_ON_VEL;
        end
        ST_OFF_VEL: begin
          result.valid    = 1'b1;
          result.kind     = KIND_NOTE_OFF;
          result.channel  = held_channel;
          result.key      = held_key;
          result.velocity = cur_byte[6:0];
        end
        ST_ON_VEL: begin
          result.valid    = 1'b1;
          result.kind     = KIND_NOTE_ON;
          result.channel  = held_channel;
          result.key      = held_key;
          result.velocity = cur_byte[6:0];
        end
        default: begin
          // drop data bytes while waiting for a status
          state_next = ST_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_WAIT;
      held_channel <= '0;
      held_key     <= '0;
    end else if (advance) begin
      state        <= state_next;
      held_channel <= held_channel_next;
      held_key     <= held_key_next;
    end
  end

endmodule

@@ sv/mnp_out_stage.sv @@
// Result register for the MIDI note message parser.
// Depends on mnp_pkg.
module mnp_out_stage
  import mnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  mnp_result_t result,
  output logic        busy,
  output logic        event_valid,
  input  logic        event_ready,
  output logic [1:0]  event_kind,
  output logic [3:0]  channel,
  output logic [6:0]  key,
  output logic [6:0]  velocity
);

  logic        valid;
  mnp_result_t held;

  assign busy        = valid && !event_ready;
  assign event_valid = valid;
  assign event_kind  = held.kind;
  assign channel     = held.channel;
  assign key         = held.key;
  assign velocity    = held.velocity;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (event_ready) begin
      valid <= 1'b0;
    end
    if (load) begin
      held <= result;
    end
  end

endmodule

@@ sv/midi_note_message_parser.sv @@
// Top level of the MIDI note message parser: input register, parse logic,
// result register. Depends on mnp_pkg, mnp_in_stage, mnp_parser, mnp_out_stage.
//
// Takes one MIDI byte per item and emits note-off, note-on and system-reset
// events. The block accepts one byte every cycle, except while a byte that
// completes an event waits on the result register. Such a byte reaches the
// result port through the input register and then the result register: the
// byte sits in the input register while the parse logic works on it, and the
// event is then loaded into the result register. A byte that causes no event
// never waits on the result port. A byte that does waits only while the
// previous event sits untaken, and byte_ready follows event_ready in the same
// cycle. Data bytes with no preceding note status are dropped; there is no running status.
`include "midi_note_message_parser_macros.svh"

module midi_note_message_parser
  import mnp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  output logic       event_valid,
  input  logic       event_ready,
  output logic [1:0] event_kind,
  output logic [3:0] channel,
  output logic [6:0] key,
  output logic [6:0] velocity
);

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        advance;
  logic        out_busy;
  mnp_result_t result;

  // advance a held item unless it has an event and the result register is full and not being taken
  assign advance = held_valid && !(result.valid && out_busy);

  mnp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  mnp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cur_byte (held_byte),
    .result   (result)
  );

  mnp_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && result.valid),
    .result      (result),
    .busy        (out_busy),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_kind  (event_kind),
    .channel     (channel),
    .key         (key),
    .velocity    (velocity)
  );

  `MNP_ASSERT_NOW(a_no_overwrite, clk, rst, advance && result.valid, !out_busy,
                  "event overwritten")
  `MNP_ASSERT_NOW(a_reset_fields, clk, rst,
                  event_valid && (event_kind == KIND_RESET),
                  (channel == 4'd0) && (key == 7'd0) && (velocity == 7'd0),
                  "reset event carries nonzero fields")
  `MNP_ASSERT_NOW(a_empty_ready, clk, rst, !held_valid, byte_ready,
                  "empty input stage not ready")
  `MNP_ASSERT_NEXT(a_accept_held, clk, rst, byte_valid && byte_ready, held_valid,
                   "accepted byte not held")

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for midi_note_message_parser: a directed table, then random
// MIDI byte streams, checked against a behavioral parser model or typed table rows.
// Depends on mnp_pkg and the midi_note_message_parser RTL.
module testbench
  import mnp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_DIRECTED = 25;
  localparam int RANDOM_ITEMS = 525;
  localparam int HOLD_OFF_CYCLES = 120;
  // Longest correct stall is the receiver hold-off; allow several times that.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int END_CYCLES = 8;

  typedef struct packed {
    event_kind_t kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [6:0]  velocity;
  } note_event_t;

  typedef enum logic [1:0] {
    CHECK_PREDICTED,
    CHECK_TYPED_EVENT,
    CHECK_TYPED_QUIET
  } row_check_t;

  typedef struct packed {
    logic [7:0]  midi_byte;
    row_check_t  check;
    note_event_t typed_event;
  } stim_row_t;

  typedef enum logic [2:0] {
    AWAIT_STATUS,
    OFF_KEY,
    OFF_VEL,
    ON_KEY,
    ON_VEL
  } parse_phase_t;

  localparam note_event_t NO_EVENT = '{KIND_NOTE_OFF, 4'd0, 7'd0, 7'd0};

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{8'h45, CHECK_TYPED_QUIET, NO_EVENT},    // data byte with no status seen
    '{8'h00, CHECK_TYPED_QUIET, NO_EVENT},
    '{8'h80, CHECK_TYPED_QUIET, NO_EVENT},
    '{8'h00, CHECK_TYPED_QUIET, NO_EVENT},
    '{8'h00, CHECK_TYPED_EVENT, '{KIND_NOTE_OFF, 4'd0, 7'd0, 7'd0}},
    '{8'h9F, CHECK_TYPED_QUIET, NO_EVENT},
    '{8'h7F, CHECK_TYPED_QUIET, NO_EVENT},
    '{8'h7F, CHECK_TYPED_EVENT, '{KIND_NOTE_ON, 4'd15, 7'd127, 7'd127}},
    '{8'hFF, CHECK_TYPED_EVENT, '{KIND_RESET, 4'd0, 7'd0, 7'd0}},
    '{8'h93, CHECK_PREDICTED, NO_EVENT},
    '{8'h3C, CHECK_PREDICTED, NO_EVENT},
    '{8'h91, CHECK_PREDICTED, NO_EVENT},      // new status drops the partial note
    '{8'h2A, CHECK_PREDICTED, NO_EVENT},
    '{8'h55, CHECK_PREDICTED, NO_EVENT},
    '{8'h11, CHECK_TYPED_QUIET, NO_EVENT},    // no running status
    '{8'hB5, CHECK_PREDICTED, NO_EVENT},      // control change: data ignored
    '{8'h10, CHECK_PREDICTED, NO_EVENT},
    '{8'h20, CHECK_PREDICTED, NO_EVENT},
    '{8'hF0, CHECK_PREDICTED, NO_EVENT},
    '{8'h8A, CHECK_PREDICTED, NO_EVENT},
    '{8'h5A, CHECK_PREDICTED, NO_EVENT},
    '{8'hFE, CHECK_PREDICTED, NO_EVENT},      // system status mid-message
    '{8'h33, CHECK_PREDICTED, NO_EVENT},
    '{8'h84, CHECK_PREDICTED, NO_EVENT},
    '{8'hFF, CHECK_TYPED_EVENT, '{KIND_RESET, 4'd0, 7'd0, 7'd0}}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  logic [7:0] data_byte = 8'h00;
  logic       event_valid;
  logic       event_ready = 1'b0;
  logic [1:0] event_kind;
  logic [3:0] channel;
  logic [6:0] key;
  logic [6:0] velocity;

  // parser model state
  parse_phase_t parse_phase = AWAIT_STATUS;
  logic [3:0]   held_channel = 4'd0;
  logic [6:0]   held_key = 7'd0;

  note_event_t expected_events [$];
  int fail_count = 0;
  int idle_cycles = 0;
  int counted_items = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 47;
  bit hold_off_req = 1'b0;

  midi_note_message_parser dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .data_byte   (data_byte),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_kind  (event_kind),
    .channel     (channel),
    .key         (key),
    .velocity    (velocity)
  );

  always #2 clk = ~clk;

  // Advance the parser model by one byte; return 1 when the byte completes an event.
  function automatic bit decode_midi_byte(input logic [7:0] b, output note_event_t ev);
    bit got;
    got = 1'b0;
    ev = NO_EVENT;
    if (b[STATUS_BIT]) begin
      parse_phase = AWAIT_STATUS;
      if (b[7:4] == CMD_SYSTEM) begin
        if (b == SYS_RESET_BYTE) begin
          ev.kind = KIND_RESET;
          got = 1'b1;
        end
      end else begin
        held_channel = b[3:0];
        if (b[6:4] == CMD_NOTE_OFF) parse_phase = OFF_KEY;
        else if (b[6:4] == CMD_NOTE_ON) parse_phase = ON_KEY;
      end
    end else begin
      case (parse_phase)
        OFF_KEY: begin
          held_key = b[6:0];
          parse_phase = OFF_VEL;
        end
        ON_KEY: begin
          held_key = b[6:0];
          parse_phase = ON_VEL;
        end
        OFF_VEL, ON_VEL: begin
          ev = '{(parse_phase == ON_VEL) ? KIND_NOTE_ON : KIND_NOTE_OFF,
                 held_channel, held_key, b[6:0]};
          parse_phase = AWAIT_STATUS;
          got = 1'b1;
        end
        default: parse_phase = AWAIT_STATUS;
      endcase
    end
    return got;
  endfunction

  function automatic logic [7:0] rand_data();
    return {1'b0, 7'($urandom())};
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < 10) $display("%s", msg);
    fail_count++;
  endfunction

  // Offer one byte and return at the edge that accepts it.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!byte_ready);
  endtask

  task automatic deliver(input logic [7:0] b);
    note_event_t ev;
    send_byte(b);
    counted_items++;
    if (decode_midi_byte(b, ev)) expected_events.push_back(ev);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_message();
    int pick;
    int n;
    logic [3:0] ch;
    logic [7:0] note_status;
    pick = $urandom_range(99);
    ch = 4'($urandom_range(15));
    note_status = {1'b1, 2'b00, 1'($urandom_range(1)), ch};
    if (pick < 60) begin
      deliver(note_status);
      deliver(rand_data());
      deliver(rand_data());
    end else if (pick < 70) begin
      // note cut short by another status
      deliver(note_status);
      if ($urandom_range(1)) deliver(rand_data());
      deliver(8'($urandom_range(8'h80, 8'hFF)));
    end else if (pick < 78) begin
      deliver({1'b1, 3'($urandom_range(2, 6)), ch});
      n = $urandom_range(3);
      repeat (n) deliver(rand_data());
    end else if (pick < 84) begin
      deliver(SYS_RESET_BYTE);
    end else if (pick < 90) begin
      deliver(8'($urandom_range(8'hF0, 8'hFE)));
    end else begin
      deliver(8'($urandom()));
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        event_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        event_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    note_event_t want;
    if (!rst && event_valid && event_ready) begin
      if (expected_events.size() == 0) begin
        note_failure($sformatf("unexpected event: kind=%0d ch=%0d key=%0d vel=%0d",
                               event_kind, channel, key, velocity));
      end else begin
        want = expected_events.pop_front();
        if (event_kind !== want.kind || channel !== want.channel ||
            key !== want.key || velocity !== want.velocity)
          note_failure($sformatf(
            "event mismatch: expected kind=%0d ch=%0d key=%0d vel=%0d, got %0d %0d %0d %0d",
            want.kind, want.channel, want.key, want.velocity,
            event_kind, channel, key, velocity));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (event_valid && event_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : stimulus
    note_event_t ev;
    bit got;
    int phase;
    int next_phase;
    int next_hold_at;
    phase = 0;
    next_hold_at = 90;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(directed_rows[i].midi_byte);
      got = decode_midi_byte(directed_rows[i].midi_byte, ev);
      case (directed_rows[i].check)
        CHECK_PREDICTED:   if (got) expected_events.push_back(ev);
        CHECK_TYPED_EVENT: expected_events.push_back(directed_rows[i].typed_event);
        default: ;
      endcase
    end

    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      next_phase = (counted_items < RANDOM_ITEMS / 3) ? 0 :
                   (counted_items < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
      if (next_phase != phase) begin
        // let every pending event drain before changing the idle pattern
        wait_drained();
        phase = next_phase;
        send_idle_pct = (phase == 1) ? 47 : 0;
        recv_idle_pct = (phase == 1) ? 28 : 0;
      end
      if (counted_items >= next_hold_at) begin
        hold_off_req = 1'b1;
        next_hold_at += 370;
      end
      send_random_message();
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/mnp_pkg.sv
sv/mnp_in_stage.sv
sv/mnp_parser.sv
sv/mnp_out_stage.sv
sv/midi_note_message_parser.sv
test/testbench.sv
